### rtl/core/srtl_pkg.sv
`default_nettype none
package srtl_pkg;
  localparam int unsigned MaxRegionsDefault = 32;
  localparam int unsigned AddrW = 64;
  localparam int unsigned FlagsW = 32;
  localparam int unsigned SlotOutW = 5;
  localparam int unsigned CountOutW = 6;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_RANGE = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef struct packed {
    logic [AddrW-1:0]  start_addr;
    logic [AddrW-1:0]  end_addr;
    logic [FlagsW-1:0] flags;
  } region_t;

  typedef struct packed {
    status_t              status;
    region_t              region;
    logic [SlotOutW-1:0]  slot;
    logic                 cache_hit;
    logic [CountOutW-1:0] count;
  } result_t;
endpackage
`default_nettype wire

### rtl/core/srtl_mem.sv
`default_nettype none
module srtl_mem #(
  parameter int unsigned Depth = srtl_pkg::MaxRegionsDefault,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [IdxW-1:0]     wr_idx,
  input  srtl_pkg::region_t        wr_data,
  input  wire logic [IdxW-1:0]     rd_idx,
  output srtl_pkg::region_t        rd_data
);
  srtl_pkg::region_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end
endmodule
`default_nettype wire

### rtl/core/srtl_ctrl.sv
`default_nettype none
module srtl_ctrl #(
  parameter int unsigned Depth = srtl_pkg::MaxRegionsDefault,
  localparam int unsigned IdxW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  srtl_pkg::func_t                    cmd_func,
  input  wire logic [srtl_pkg::AddrW-1:0]    cmd_addr,
  input  srtl_pkg::region_t                  cmd_region,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output srtl_pkg::result_t                  res_data,
  output logic                               wr_en,
  output logic [IdxW-1:0]                    wr_idx,
  output srtl_pkg::region_t                  wr_data,
  output logic [IdxW-1:0]                    rd_idx,
  input  srtl_pkg::region_t                  rd_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_CACHE, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_DONE
  } state_t;

  state_t                         state_r;
  srtl_pkg::func_t                func_r;
  logic [srtl_pkg::AddrW-1:0]     addr_r;
  srtl_pkg::region_t              new_r;
  logic [CntW-1:0]                count_r;
  logic [IdxW-1:0]                cache_slot_r;
  logic                           cache_valid_r;
  logic [CntW-1:0]                idx_r;
  logic                           have_prev_r;
  srtl_pkg::region_t              prev_r;
  srtl_pkg::region_t              hold_r;
  logic                           res_valid_r;
  srtl_pkg::result_t              res_r;
  logic [CntW-1:0]                pos_r;

  logic hit_cur;
  logic stop_ins;

  assign cmd_ready = (state_r == S_IDLE) && !res_valid_r;
  assign res_valid = res_valid_r;
  assign res_data  = res_r;
  assign hit_cur   = (rd_data.start_addr <= addr_r) && (addr_r < rd_data.end_addr);
  assign stop_ins  = rd_data.start_addr > new_r.start_addr;

  always_comb begin
    rd_idx  = idx_r[IdxW-1:0];
    wr_en   = 1'b0;
    wr_idx  = idx_r[IdxW-1:0];
    wr_data = hold_r;
    if (state_r == S_IDLE && cmd_valid && cmd_ready) begin
      rd_idx = (cmd_func == srtl_pkg::FUNC_FIND) ? cache_slot_r : '0;
    end else if (state_r == S_SCAN) begin
      rd_idx = idx_r[IdxW-1:0] + IdxW'(1);
    end else if (state_r == S_SHIFT_WR) begin
      wr_en = 1'b1;
      if (idx_r == pos_r) begin
        wr_data = new_r;
      end
    end
  end

  function automatic srtl_pkg::result_t mk(srtl_pkg::status_t st, logic [CntW-1:0] cnt,
                                           srtl_pkg::region_t rg, logic [CntW-1:0] slot,
                                           logic hit);
    srtl_pkg::result_t r;
    r           = '0;
    r.status    = st;
    r.region    = rg;
    r.slot      = srtl_pkg::SlotOutW'(slot);
    r.cache_hit = hit;
    r.count     = srtl_pkg::CountOutW'(cnt);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      cache_slot_r  <= '0;
      cache_valid_r <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            func_r      <= cmd_func;
            addr_r      <= cmd_addr;
            new_r       <= cmd_region;
            idx_r       <= '0;
            have_prev_r <= 1'b0;
            unique case (cmd_func)
              srtl_pkg::FUNC_INSERT: begin
                if (cmd_region.start_addr >= cmd_region.end_addr) begin
                  res_r       <= mk(srtl_pkg::ST_BAD_RANGE, count_r, '0, '0, 1'b0);
                  res_valid_r <= 1'b1;
                end else if (count_r == '0) begin
                  pos_r <= '0;
                  idx_r <= '0;
                  hold_r <= cmd_region;
                  state_r <= S_SHIFT_WR;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              srtl_pkg::FUNC_FIND: begin
                state_r <= S_CACHE;
              end
              srtl_pkg::FUNC_CLEAR: begin
                count_r       <= '0;
                cache_slot_r  <= '0;
                cache_valid_r <= 1'b0;
                res_r         <= mk(srtl_pkg::ST_OK, '0, '0, '0, 1'b0);
                res_valid_r   <= 1'b1;
              end
              default: begin
                res_r       <= mk(srtl_pkg::ST_OK, count_r, '0, '0, 1'b0);
                res_valid_r <= 1'b1;
              end
            endcase
          end
        end
        S_CACHE: begin
          if (cache_valid_r && (CntW'(cache_slot_r) < count_r) && hit_cur) begin
            res_r       <= mk(srtl_pkg::ST_OK, count_r, rd_data, CntW'(cache_slot_r), 1'b1);
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (count_r == '0) begin
            res_r       <= mk(srtl_pkg::ST_NOT_FOUND, count_r, '0, '0, 1'b0);
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (func_r == srtl_pkg::FUNC_FIND) begin
            if (hit_cur) begin
              cache_slot_r  <= idx_r[IdxW-1:0];
              cache_valid_r <= 1'b1;
              res_r         <= mk(srtl_pkg::ST_OK, count_r, rd_data, idx_r, 1'b0);
              res_valid_r   <= 1'b1;
              state_r       <= S_IDLE;
            end else if (idx_r + 1'b1 >= count_r) begin
              res_r       <= mk(srtl_pkg::ST_NOT_FOUND, count_r, '0, '0, 1'b0);
              res_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            if (stop_ins || idx_r + 1'b1 >= count_r) begin
              if (stop_ins) begin
                if ((have_prev_r && prev_r.end_addr > new_r.start_addr) ||
                    (new_r.end_addr > rd_data.start_addr)) begin
                  res_r       <= mk(srtl_pkg::ST_OVERLAP, count_r, '0, '0, 1'b0);
                  res_valid_r <= 1'b1;
                  state_r     <= S_IDLE;
                end else if (count_r >= CntW'(Depth)) begin
                  res_r       <= mk(srtl_pkg::ST_FULL, count_r, '0, '0, 1'b0);
                  res_valid_r <= 1'b1;
                  state_r     <= S_IDLE;
                end else begin
                  pos_r   <= idx_r;
                  idx_r   <= idx_r;
                  hold_r  <= rd_data;
                  state_r <= S_SHIFT_WR;
                end
              end else begin
                if (rd_data.end_addr > new_r.start_addr) begin
                  res_r       <= mk(srtl_pkg::ST_OVERLAP, count_r, '0, '0, 1'b0);
                  res_valid_r <= 1'b1;
                  state_r     <= S_IDLE;
                end else if (count_r >= CntW'(Depth)) begin
                  res_r       <= mk(srtl_pkg::ST_FULL, count_r, '0, '0, 1'b0);
                  res_valid_r <= 1'b1;
                  state_r     <= S_IDLE;
                end else begin
                  pos_r   <= count_r;
                  idx_r   <= count_r;
                  hold_r  <= new_r;
                  state_r <= S_SHIFT_WR;
                end
              end
            end else begin
              prev_r      <= rd_data;
              have_prev_r <= 1'b1;
              idx_r       <= idx_r + 1'b1;
            end
          end
        end
        S_SHIFT_WR: begin
          if (idx_r == count_r) begin
            if (cache_valid_r && CntW'(cache_slot_r) >= pos_r) begin
              cache_slot_r <= cache_slot_r + 1'b1;
            end
            count_r     <= count_r + 1'b1;
            res_r       <= mk(srtl_pkg::ST_OK, count_r + 1'b1, '0, pos_r, 1'b0);
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SHIFT_RD;
          end
        end
        S_SHIFT_RD: begin
          hold_r  <= rd_data;
          state_r <= S_SHIFT_WR;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/sorted_region_table_lookup.sv
`default_nettype none
// Channel | Direction | Fields
// in_     | input     | tdata: func, addr, region_start, region_end, region_flags
// out_    | output    | tdata: status, found_start, found_end, found_flags, found_slot,
//         |           |        cache_hit, entry_count
// One item is processed at a time. A find answers on a cache hit without a scan, and
// otherwise scans up to N regions, one memory read per cycle. Insert scans up to N
// entries, then shifts later entries with one read and one write each. Reset empties
// the table and the cache. A result waits in its register until taken; the next item
// can be accepted in the cycle after it is taken.
module sorted_region_table_lookup #(
  parameter int unsigned MAX_REGIONS = srtl_pkg::MaxRegionsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // func[1:0], addr[65:2], region_start[129:66], region_end[193:130],
  // region_flags[225:194], zero fill to 232
  input  wire logic [231:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[2:0], found_start[66:3], found_end[130:67], found_flags[162:131],
  // found_slot[167:163], cache_hit[168], entry_count[174:169], zero fill to 176
  output logic [175:0]      out_tdata
);
  localparam int unsigned IdxW = $clog2(MAX_REGIONS);

  srtl_pkg::region_t cmd_region;
  srtl_pkg::result_t res;
  srtl_pkg::region_t wr_data;
  srtl_pkg::region_t rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [IdxW-1:0]   rd_idx;

  assign cmd_region.start_addr = in_tdata[129:66];
  assign cmd_region.end_addr   = in_tdata[193:130];
  assign cmd_region.flags      = in_tdata[225:194];

  srtl_mem #(.Depth(MAX_REGIONS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_idx(rd_idx), .rd_data(rd_data)
  );

  srtl_ctrl #(.Depth(MAX_REGIONS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(in_tvalid), .cmd_ready(in_tready),
    .cmd_func(srtl_pkg::func_t'(in_tdata[1:0])),
    .cmd_addr(in_tdata[65:2]), .cmd_region(cmd_region),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
    .rd_idx(rd_idx), .rd_data(rd_data)
  );

  assign out_tdata = {1'b0, res.count, res.cache_hit, res.slot,
                      res.region.flags, res.region.end_addr, res.region.start_addr,
                      res.status};
endmodule
`default_nettype wire
